FILE: design/bom_pkg.sv
// ----------------------------------------------------------------------------
// bom_pkg
// shared types and constants for the box overlap max scorer
// ----------------------------------------------------------------------------
package bom_pkg;

   // command codes on req_func, code 3 is unused
   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_SCORE  = 2'd2
   } func_type;

   // register port geometry: word index in paddr[2], byte offset below it
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IOU_THRESHOLD = 1'b0;

endpackage

FILE: design/box_overlap_max_scorer.sv
// ----------------------------------------------------------------------------
// box_overlap_max_scorer
// best intersection-over-union of a proposal box against a stored table of
// ground-truth boxes (inclusive pixel corners, widths add one)
// ----------------------------------------------------------------------------
//
// channel    ports                        handshake
// ---------  ---------------------------  ----------------------------------
// request    req_func, req_box_*          start high while busy low
// response   rsp_best_overlap,            rsp_valid strobe, one cycle, taken
//            rsp_is_positive              at the edge that ends it
// registers  psel/penable/pwrite/paddr    write on psel & penable & pwrite,
//            pwdata/prdata/pready         pready always high
//
// clear and append transactions complete in the accept cycle, busy stays low
// a score transaction keeps busy high until its result is registered; an
// empty table goes straight to the finishing step
// the shared multiplier forms two products per overlapping box and one
// proposal area per score, and boxes that overlap go through the
// one-bit-per-cycle restoring divider
// reset is synchronous, active high; it empties the table and restores the
// threshold to one half; the receiver cannot stall, so results never wait
// ----------------------------------------------------------------------------

module box_overlap_max_scorer
   import bom_pkg::*;
#(
   parameter int MAX_BOXES  = 64,
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   // request transaction
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic signed [COORD_BITS-1:0]  req_box_x1,
   input  logic signed [COORD_BITS-1:0]  req_box_y1,
   input  logic signed [COORD_BITS-1:0]  req_box_x2,
   input  logic signed [COORD_BITS-1:0]  req_box_y2,

   // response transaction
   output logic                          rsp_valid,
   output logic [FRAC_BITS:0]            rsp_best_overlap,
   output logic                          rsp_is_positive,

   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   // span width holds 1 .. 2^COORD_BITS, products and union follow from it
   localparam int W      = COORD_BITS + 1;
   localparam int PROD_W = 2 * W;
   localparam int UNI_W  = PROD_W + 1;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int STEP_W = $clog2(FRAC_BITS);
   localparam int CNT_W  = $clog2(MAX_BOXES + 1);
   localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int BOX_W  = 4 * COORD_BITS;
   localparam logic [Q_W-1:0] THR_RESET = Q_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_AREA,
      S_READ,
      S_ISECT,
      S_MUL_I,
      S_MUL_B,
      S_UNION,
      S_DIV0,
      S_DIV,
      S_MAX,
      S_DONE
   } state_type;

   // signed span hi - lo + 1, one bit wider than needed for the width itself
   function automatic logic signed [W:0] span(input logic signed [COORD_BITS-1:0] lo,
                                              input logic signed [COORD_BITS-1:0] hi);
      logic signed [W:0] h;
      logic signed [W:0] l;
      h = $signed({{2{hi[COORD_BITS-1]}}, hi});
      l = $signed({{2{lo[COORD_BITS-1]}}, lo});
      span = h - l + $signed((W+1)'(1));
   endfunction

   // ---- registers ----
   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [Q_W-1:0]              thr_ff, thr_in;

   logic signed [COORD_BITS-1:0] px1_ff, px1_in, py1_ff, py1_in;
   logic signed [COORD_BITS-1:0] px2_ff, px2_in, py2_ff, py2_in;
   logic [W-1:0]                pw_ff, pw_in, ph_ff, ph_in;
   logic [W-1:0]                iw_ff, iw_in, ih_ff, ih_in;
   logic [W-1:0]                wb_ff, wb_in, hb_ff, hb_in;
   logic [PROD_W-1:0]           area_a_ff, area_a_in;
   logic [PROD_W-1:0]           area_b_ff, area_b_in;
   logic [PROD_W-1:0]           inter_ff, inter_in;
   logic [UNI_W-1:0]            uni_ff, uni_in;
   logic [UNI_W-1:0]            rem_ff, rem_in;
   logic [Q_W-1:0]              q_ff, q_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [Q_W-1:0]              best_ff, best_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]              rsp_best_ff, rsp_best_in;
   logic                        rsp_pos_ff, rsp_pos_in;

   // ---- box table ----
   logic [BOX_W-1:0]            mem [MAX_BOXES];
   logic [BOX_W-1:0]            rd_ff;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_waddr;
   logic [BOX_W-1:0]            mem_wdata;

   // ---- shared multiplier ----
   logic [W-1:0]                mul_a, mul_b;
   logic [PROD_W-1:0]           prod;

   logic                        cfg_write;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_best_overlap = rsp_best_ff;
   assign rsp_is_positive  = rsp_pos_ff;
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite
                      && (paddr[CSR_ADDR_W-1:2] == REG_IOU_THRESHOLD);
   assign prdata    = (paddr[CSR_ADDR_W-1:2] == REG_IOU_THRESHOLD)
                      ? CSR_DATA_W'(thr_ff) : '0;

   // operand select for the one multiplier: proposal area, intersection,
   // stored box area
   always_comb begin
      unique case (state_ff)
         S_AREA: begin
            mul_a = pw_ff;
            mul_b = ph_ff;
         end
         S_MUL_I: begin
            mul_a = iw_ff;
            mul_b = ih_ff;
         end
         default: begin
            mul_a = wb_ff;
            mul_b = hb_ff;
         end
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // ---- sequencer next state ----
   always_comb begin
      logic signed [COORD_BITS-1:0] bx1, by1, bx2, by2;
      logic signed [COORD_BITS-1:0] ixl, ixh, iyl, iyh;
      logic signed [W:0]            iw_s, ih_s, wb_s, hb_s, pw_s, ph_s;
      logic                         ovl;
      logic [CNT_W-1:0]             idx_next;
      logic [UNI_W-1:0]             inter_u;
      logic                         q0;
      logic [UNI_W:0]               r2, dv;
      logic                         ge;

      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      thr_in      = thr_ff;
      px1_in      = px1_ff;
      py1_in      = py1_ff;
      px2_in      = px2_ff;
      py2_in      = py2_ff;
      pw_in       = pw_ff;
      ph_in       = ph_ff;
      iw_in       = iw_ff;
      ih_in       = ih_ff;
      wb_in       = wb_ff;
      hb_in       = hb_ff;
      area_a_in   = area_a_ff;
      area_b_in   = area_b_ff;
      inter_in    = inter_ff;
      uni_in      = uni_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      step_in     = step_ff;
      best_in     = best_ff;
      rsp_valid_in = 1'b0;
      rsp_best_in = rsp_best_ff;
      rsp_pos_in  = rsp_pos_ff;
      mem_we      = 1'b0;
      mem_waddr   = count_ff[IDX_W-1:0];
      mem_wdata   = {req_box_x1, req_box_y1, req_box_x2, req_box_y2};

      bx1 = $signed(rd_ff[4*COORD_BITS-1:3*COORD_BITS]);
      by1 = $signed(rd_ff[3*COORD_BITS-1:2*COORD_BITS]);
      bx2 = $signed(rd_ff[2*COORD_BITS-1:COORD_BITS]);
      by2 = $signed(rd_ff[COORD_BITS-1:0]);
      ixl = (px1_ff >= bx1) ? px1_ff : bx1;
      ixh = (px2_ff <= bx2) ? px2_ff : bx2;
      iyl = (py1_ff >= by1) ? py1_ff : by1;
      iyh = (py2_ff <= by2) ? py2_ff : by2;
      iw_s = span(ixl, ixh);
      ih_s = span(iyl, iyh);
      wb_s = span(bx1, bx2);
      hb_s = span(by1, by2);
      pw_s = span(req_box_x1, req_box_x2);
      ph_s = span(req_box_y1, req_box_y2);
      // both spans positive: sign clear and not zero
      ovl = !iw_s[W] && (iw_s != '0) && !ih_s[W] && (ih_s != '0);

      idx_next = idx_ff + CNT_W'(1);

      inter_u = UNI_W'(inter_ff);
      q0      = (inter_u >= uni_ff);
      r2      = {rem_ff, 1'b0};
      dv      = r2 - {1'b0, uni_ff};
      ge      = (r2 >= {1'b0, uni_ff});

      if (cfg_write) begin
         thr_in = pwdata[Q_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (func_type'(req_func))
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_APPEND: begin
                     // appends past capacity are dropped
                     if (count_ff != CNT_W'(MAX_BOXES)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_SCORE: begin
                     px1_in  = req_box_x1;
                     py1_in  = req_box_y1;
                     px2_in  = req_box_x2;
                     py2_in  = req_box_y2;
                     pw_in   = pw_s[W-1:0];
                     ph_in   = ph_s[W-1:0];
                     idx_in  = '0;
                     best_in = '0;
                     state_in = (count_ff == '0) ? S_DONE : S_AREA;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_AREA: begin
            // box 0 is read from the table in this same cycle
            area_a_in = prod;
            state_in  = S_ISECT;
         end
         S_READ: begin
            state_in = S_ISECT;
         end
         S_ISECT: begin
            iw_in = iw_s[W-1:0];
            ih_in = ih_s[W-1:0];
            wb_in = wb_s[W-1:0];
            hb_in = hb_s[W-1:0];
            if (ovl) begin
               state_in = S_MUL_I;
            end else if (idx_next == count_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_next;
               state_in = S_READ;
            end
         end
         S_MUL_I: begin
            inter_in = prod;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            area_b_in = prod;
            state_in  = S_UNION;
         end
         S_UNION: begin
            uni_in   = UNI_W'(area_a_ff) + UNI_W'(area_b_ff) - inter_u;
            state_in = S_DIV0;
         end
         S_DIV0: begin
            // integer bit of the quotient, set only when overlap is exactly one
            q_in     = Q_W'(q0);
            rem_in   = q0 ? (inter_u - uni_ff) : inter_u;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? dv[UNI_W-1:0] : r2[UNI_W-1:0];
            q_in   = {q_ff[Q_W-2:0], ge};
            if (step_ff == STEP_W'(FRAC_BITS - 1)) begin
               state_in = S_MAX;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_MAX: begin
            if (q_ff >= best_ff) begin
               best_in = q_ff;
            end
            if (idx_next == count_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_next;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_best_in  = best_ff;
            rsp_pos_in   = (best_ff >= thr_ff);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---- state and registered outputs ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px1_ff      <= px1_in;
      py1_ff      <= py1_in;
      px2_ff      <= px2_in;
      py2_ff      <= py2_in;
      pw_ff       <= pw_in;
      ph_ff       <= ph_in;
      iw_ff       <= iw_in;
      ih_ff       <= ih_in;
      wb_ff       <= wb_in;
      hb_ff       <= hb_in;
      area_a_ff   <= area_a_in;
      area_b_ff   <= area_b_in;
      inter_ff    <= inter_in;
      uni_ff      <= uni_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
      best_ff     <= best_in;
      rsp_best_ff <= rsp_best_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   // ---- box table, one write and one registered read per cycle ----
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[idx_ff[IDX_W-1:0]];
   end

   // ---- assertions ----

   // a response only follows the finishing step of a score
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_DONE))
      else $error("response strobe without a finished score");

   // table fill never passes capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BOXES))
      else $error("box count above capacity");

   // partial remainder stays below the union while dividing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < uni_ff))
      else $error("divider remainder out of range");

   // an accepted score always holds the request side off next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == FUNC_SCORE)) |=> busy)
      else $error("score accepted but block not busy");

   // overlap never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_best_ff <= (Q_W'(1) << FRAC_BITS)))
      else $error("overlap above one");

endmodule
